/* design/nstld_pkg.sv */
// ----------------------------------------------------------------------------
// nstld_pkg
// Shared types, constants and small tables of the seconds-to-local-date block.
// ----------------------------------------------------------------------------
package nstld_pkg;

    // Pipeline depth and the role of each stage
    localparam int NUM_STAGES = 10;
    localparam int ST_OFFSET  = 0;   // zone offset and bias day added
    localparam int ST_DAYNO   = 1;   // day number by reciprocal multiply
    localparam int ST_SOD     = 2;   // second of day, era split
    localparam int ST_HOUR    = 3;   // hour, weekday, century terms
    localparam int ST_REM     = 4;   // second of hour, era day count
    localparam int ST_MIN     = 5;   // minute, year of era
    localparam int ST_SEC     = 6;   // second, day of year
    localparam int ST_MP      = 7;   // March-based month index
    localparam int ST_DATE    = 8;   // day, month, year
    localparam int ST_OUT     = 9;   // summer rule and output register

    // Time constants
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;

    // Exact reciprocals: floor(x / d) == (x * RECIP) >> SHIFT over the value range
    localparam logic [26:0] DAY_RECIP  = 27'd101806633;  // (t >> 7) / 675, shift 36
    localparam logic [17:0] WDAY_RECIP = 18'd149797;     // / 7, shift 20
    localparam logic [12:0] HOUR_RECIP = 13'd4661;       // (sod >> 4) / 225, shift 20
    localparam logic [12:0] MIN_RECIP  = 13'd4370;       // / 60, shift 18
    localparam logic [15:0] Y365_RECIP = 16'd45965;      // / 365, shift 24
    localparam logic [10:0] MP_RECIP   = 11'd1714;       // / 153, shift 18

    // Civil calendar constants (days counted from 0000-03-01)
    localparam logic [16:0] ERA_SPLIT_DAY  = 17'd36585;   // day number where era 5 starts
    localparam logic [17:0] ERA4_DOE_BIAS  = 18'd109512;  // day of era for era 4
    localparam logic [17:0] DAYS_PER_CENT  = 18'd36524;
    localparam logic [17:0] DAYS_PER_YEAR  = 18'd365;
    localparam logic [11:0] ERA4_BASE_YEAR = 12'd1600;
    localparam logic [11:0] ERA5_BASE_YEAR = 12'd2000;
    localparam logic [11:0] EPOCH_YEAR     = 12'd1900;
    localparam logic [3:0]  MP_JANUARY     = 4'd10;

    // Month codes, January is zero
    localparam logic [3:0] MONTH_JAN = 4'd0;
    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_MAR = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd3;
    localparam logic [3:0] MONTH_MAY = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd5;
    localparam logic [3:0] MONTH_JUL = 4'd6;
    localparam logic [3:0] MONTH_AUG = 4'd7;
    localparam logic [3:0] MONTH_SEP = 4'd8;
    localparam logic [3:0] MONTH_OCT = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd10;
    localparam logic [3:0] MONTH_DEC = 4'd11;

    // Summer-time rule
    localparam logic [2:0] WDAY_SUNDAY         = 3'd0;
    localparam logic [5:0] LAST_SUNDAY_MIN_DAY = 6'd25;
    localparam logic [4:0] DST_START_HOUR      = 5'd2;
    localparam logic [4:0] DST_END_HOUR        = 5'd3;
    localparam logic [4:0] LAST_HOUR           = 5'd23;

    localparam logic signed [4:0] ZONE_OFFSET_RESET = 5'sd1;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] wday;
    } tod_t;

    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] mday;
    } date_t;

    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] mday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       summer;
    } result_t;

    // First day of year (from March 1) of each March-based month
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] days;
        unique case (mp)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    // Days in a month; February only matters outside summer time, so no leap day
    function automatic logic [4:0] month_length(input logic [3:0] month);
        logic [4:0] days;
        unique case (month)
            MONTH_FEB:                                  days = 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = 5'd30;
            default:                                    days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

/* design/nstld_stream_if.sv */
// ----------------------------------------------------------------------------
// nstld_stream_if
// Valid/ready channels for second counts in and local dates out.
// ----------------------------------------------------------------------------
interface nstld_seconds_if;
    logic        valid;
    logic        ready;
    logic [31:0] seconds_since_1900;

    modport source (output valid, output seconds_since_1900, input ready);
    modport sink   (input valid, input seconds_since_1900, output ready);
endinterface

interface nstld_date_if;
    logic       valid;
    logic       ready;
    logic [7:0] years_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
    logic       summer_time;

    modport source (output valid, output years_since_1900, output month_index,
                    output day_of_month, output hour_of_day, output minute_of_hour,
                    output second_of_minute, output summer_time, input ready);
    modport sink   (input valid, input years_since_1900, input month_index,
                    input day_of_month, input hour_of_day, input minute_of_hour,
                    input second_of_minute, input summer_time, output ready);
endinterface

/* design/nstld_ctrl.sv */
// ----------------------------------------------------------------------------
// nstld_ctrl
// Stage valid bits and per-stage load enables; bubbles collapse under stall.
// ----------------------------------------------------------------------------
module nstld_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output nstld_pkg::pipe_ctrl_t ctrl
);

    logic [nstld_pkg::NUM_STAGES-1:0] valid_reg;
    logic [nstld_pkg::NUM_STAGES-1:0] valid_next;
    logic [nstld_pkg::NUM_STAGES-1:0] adv;

    // A stage may load when it is empty or its content moves on
    always_comb
    begin
        adv[nstld_pkg::NUM_STAGES-1] = !valid_reg[nstld_pkg::NUM_STAGES-1] || out_ready;
        for (int k = nstld_pkg::NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < nstld_pkg::NUM_STAGES; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load = adv;
    assign in_ready  = adv[0];
    assign out_valid = valid_reg[nstld_pkg::NUM_STAGES-1];

endmodule

/* design/nstld_split.sv */
// ----------------------------------------------------------------------------
// nstld_split
// Zone offset, day number, time of day and weekday of the standard-time count.
// ----------------------------------------------------------------------------
module nstld_split (
    input  logic                  clk,
    input  nstld_pkg::pipe_ctrl_t ctrl,
    input  logic signed [4:0]     zone_offset,
    input  logic [31:0]           seconds,
    output logic [16:0]           dayno,
    output nstld_pkg::tod_t       tod
);

    logic signed [17:0] offset_secs;
    logic [32:0]        t_next, t_reg, t1_reg;
    logic [52:0]        day_prod;
    logic [16:0]        dayno_next, dayno_reg, dayno2_reg;
    logic [32:0]        day_secs;
    logic [16:0]        sod_next, sod_reg, sod3_reg;
    logic [34:0]        wq_prod;
    logic [13:0]        wq_next, wq_reg;
    logic [25:0]        hour_prod;
    logic [4:0]         hour_next, hour_reg, hour4_reg, hour5_reg;
    logic [16:0]        wday_diff;
    logic [2:0]         wday_next, wday_reg, wday4_reg, wday5_reg;
    logic [11:0]        rem_next, rem_reg, rem5_reg;
    logic [23:0]        min_prod;
    logic [5:0]         min_next, min_reg;
    nstld_pkg::tod_t    tod_next, tod6_reg, tod7_reg, tod8_reg;

    // Offset stage: local seconds plus one bias day, always positive
    assign offset_secs = 18'(zone_offset) * $signed(18'(nstld_pkg::SECS_PER_HOUR));
    assign t_next      = 33'(seconds) + 33'(nstld_pkg::SECS_PER_DAY) + 33'(offset_secs);

    // Day number: 86400 = 128 * 675
    assign day_prod   = 53'(t_reg[32:7]) * 53'(nstld_pkg::DAY_RECIP);
    assign dayno_next = day_prod[52:36];

    // Second of day and weekday quotient
    assign day_secs = 33'(dayno_reg) * 33'(nstld_pkg::SECS_PER_DAY);
    assign sod_next = 17'(t1_reg - day_secs);
    assign wq_prod  = 35'(dayno_reg) * 35'(nstld_pkg::WDAY_RECIP);
    assign wq_next  = wq_prod[33:20];

    // Hour: 3600 = 16 * 225
    assign hour_prod = 26'(sod_reg[16:4]) * 26'(nstld_pkg::HOUR_RECIP);
    assign hour_next = hour_prod[24:20];
    assign wday_diff = dayno2_reg - 17'(wq_reg) * 17'(nstld_pkg::DAYS_PER_WEEK);
    assign wday_next = wday_diff[2:0];

    assign rem_next = 12'(sod3_reg - 17'(hour_reg) * 17'(nstld_pkg::SECS_PER_HOUR));

    assign min_prod = 24'(rem_reg) * 24'(nstld_pkg::MIN_RECIP);
    assign min_next = min_prod[23:18];

    always_comb
    begin
        tod_next.hour   = hour5_reg;
        tod_next.minute = min_reg;
        tod_next.second = 6'(rem5_reg - 12'(min_reg) * 12'(nstld_pkg::SECS_PER_MIN));
        tod_next.wday   = wday5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[nstld_pkg::ST_OFFSET])
        begin
            t_reg <= t_next;
        end
        if (ctrl.load[nstld_pkg::ST_DAYNO])
        begin
            dayno_reg <= dayno_next;
            t1_reg    <= t_reg;
        end
        if (ctrl.load[nstld_pkg::ST_SOD])
        begin
            sod_reg    <= sod_next;
            wq_reg     <= wq_next;
            dayno2_reg <= dayno_reg;
        end
        if (ctrl.load[nstld_pkg::ST_HOUR])
        begin
            hour_reg <= hour_next;
            wday_reg <= wday_next;
            sod3_reg <= sod_reg;
        end
        if (ctrl.load[nstld_pkg::ST_REM])
        begin
            rem_reg   <= rem_next;
            hour4_reg <= hour_reg;
            wday4_reg <= wday_reg;
        end
        if (ctrl.load[nstld_pkg::ST_MIN])
        begin
            min_reg   <= min_next;
            rem5_reg  <= rem_reg;
            hour5_reg <= hour4_reg;
            wday5_reg <= wday4_reg;
        end
        // Hold the time of day until the date catches up
        if (ctrl.load[nstld_pkg::ST_SEC])
        begin
            tod6_reg <= tod_next;
        end
        if (ctrl.load[nstld_pkg::ST_MP])
        begin
            tod7_reg <= tod6_reg;
        end
        if (ctrl.load[nstld_pkg::ST_DATE])
        begin
            tod8_reg <= tod7_reg;
        end
    end

    assign dayno = dayno_reg;
    assign tod   = tod8_reg;

endmodule

/* design/nstld_civil.sv */
// ----------------------------------------------------------------------------
// nstld_civil
// Proleptic Gregorian year, month and day from a day number.
// ----------------------------------------------------------------------------
module nstld_civil (
    input  logic                  clk,
    input  nstld_pkg::pipe_ctrl_t ctrl,
    input  logic [16:0]           dayno,
    output nstld_pkg::date_t      date
);

    logic             era_hi_next, era_hi_reg, era_hi3_reg, era_hi4_reg, era_hi5_reg;
    logic             era_hi6_reg, era_hi7_reg;
    logic [17:0]      doe_next, doe_reg, doe3_reg, doe4_reg, doe5_reg;
    logic [31:0]      c1_prod;
    logic [6:0]       c1_next, c1_reg;
    logic [2:0]       c2_next, c2_reg;
    logic             c3_next, c3_reg;
    logic [17:0]      v_next, v_reg;
    logic [33:0]      y_prod;
    logic [8:0]       yoe_next, yoe_reg, yoe6_reg, yoe7_reg;
    logic [1:0]       yoe_cent;
    logic [8:0]       doy_next, doy_reg, doy7_reg;
    logic [10:0]      mp_arg;
    logic [21:0]      mp_prod;
    logic [3:0]       mp_next, mp_reg;
    logic [3:0]       month;
    logic [11:0]      year_full;
    nstld_pkg::date_t date_next, date_reg;

    // Era is 4 or 5 over the whole input range
    assign era_hi_next = (dayno >= nstld_pkg::ERA_SPLIT_DAY);
    assign doe_next    = era_hi_next ? 18'(dayno - nstld_pkg::ERA_SPLIT_DAY)
                                     : 18'(dayno) + nstld_pkg::ERA4_DOE_BIAS;

    // doe / 1460, doe / 36524, doe / 146096
    assign c1_prod = 32'(doe_reg[17:2]) * 32'(nstld_pkg::Y365_RECIP);
    assign c1_next = c1_prod[30:24];
    assign c3_next = (doe_reg == 18'(nstld_pkg::DAYS_PER_CENT * 4));

    always_comb
    begin
        priority if (doe_reg >= 18'(nstld_pkg::DAYS_PER_CENT * 4)) c2_next = 3'd4;
        else if (doe_reg >= 18'(nstld_pkg::DAYS_PER_CENT * 3))     c2_next = 3'd3;
        else if (doe_reg >= 18'(nstld_pkg::DAYS_PER_CENT * 2))     c2_next = 3'd2;
        else if (doe_reg >= nstld_pkg::DAYS_PER_CENT)              c2_next = 3'd1;
        else                                                       c2_next = 3'd0;
    end

    assign v_next = doe3_reg - 18'(c1_reg) + 18'(c2_reg) - 18'(c3_reg);

    assign y_prod   = 34'(v_reg) * 34'(nstld_pkg::Y365_RECIP);
    assign yoe_next = y_prod[32:24];

    always_comb
    begin
        priority if (yoe_reg >= 9'd300) yoe_cent = 2'd3;
        else if (yoe_reg >= 9'd200)     yoe_cent = 2'd2;
        else if (yoe_reg >= 9'd100)     yoe_cent = 2'd1;
        else                            yoe_cent = 2'd0;
    end

    assign doy_next = 9'(doe5_reg - (18'(yoe_reg) * nstld_pkg::DAYS_PER_YEAR
                                     + 18'(yoe_reg[8:2]) - 18'(yoe_cent)));

    assign mp_arg  = 11'(doy_reg) * 11'd5 + 11'd2;
    assign mp_prod = 22'(mp_arg) * 22'(nstld_pkg::MP_RECIP);
    assign mp_next = mp_prod[21:18];

    // Month index is March based; January and February belong to the next year
    assign month = (mp_reg < nstld_pkg::MP_JANUARY) ? mp_reg + 4'd2
                                                    : mp_reg - nstld_pkg::MP_JANUARY;

    always_comb
    begin
        year_full = 12'(yoe7_reg)
                  + (era_hi7_reg ? nstld_pkg::ERA5_BASE_YEAR : nstld_pkg::ERA4_BASE_YEAR)
                  + ((month < nstld_pkg::MONTH_MAR) ? 12'd1 : 12'd0);
        date_next.year  = 8'(year_full - nstld_pkg::EPOCH_YEAR);
        date_next.month = month;
        date_next.mday  = 5'(doy7_reg - nstld_pkg::month_start(mp_reg) + 9'd1);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[nstld_pkg::ST_SOD])
        begin
            doe_reg    <= doe_next;
            era_hi_reg <= era_hi_next;
        end
        if (ctrl.load[nstld_pkg::ST_HOUR])
        begin
            c1_reg      <= c1_next;
            c2_reg      <= c2_next;
            c3_reg      <= c3_next;
            doe3_reg    <= doe_reg;
            era_hi3_reg <= era_hi_reg;
        end
        if (ctrl.load[nstld_pkg::ST_REM])
        begin
            v_reg       <= v_next;
            doe4_reg    <= doe3_reg;
            era_hi4_reg <= era_hi3_reg;
        end
        if (ctrl.load[nstld_pkg::ST_MIN])
        begin
            yoe_reg     <= yoe_next;
            doe5_reg    <= doe4_reg;
            era_hi5_reg <= era_hi4_reg;
        end
        if (ctrl.load[nstld_pkg::ST_SEC])
        begin
            doy_reg     <= doy_next;
            yoe6_reg    <= yoe_reg;
            era_hi6_reg <= era_hi5_reg;
        end
        if (ctrl.load[nstld_pkg::ST_MP])
        begin
            mp_reg      <= mp_next;
            doy7_reg    <= doy_reg;
            yoe7_reg    <= yoe6_reg;
            era_hi7_reg <= era_hi6_reg;
        end
        if (ctrl.load[nstld_pkg::ST_DATE])
        begin
            date_reg <= date_next;
        end
    end

    assign date = date_reg;

endmodule

/* design/nstld_dst.sv */
// ----------------------------------------------------------------------------
// nstld_dst
// European summer-time rule and summer-hour adjustment into the output register.
// ----------------------------------------------------------------------------
module nstld_dst (
    input  logic                  clk,
    input  nstld_pkg::pipe_ctrl_t ctrl,
    input  nstld_pkg::date_t      date,
    input  nstld_pkg::tod_t       tod,
    output nstld_pkg::result_t    result
);

    logic               past_last_sunday;
    logic               not_sunday;
    logic               summer;
    logic               day_roll;
    nstld_pkg::result_t result_next, result_reg;

    assign past_last_sunday = (6'(date.mday) >= 6'(tod.wday) + nstld_pkg::LAST_SUNDAY_MIN_DAY);
    assign not_sunday       = (tod.wday != nstld_pkg::WDAY_SUNDAY);

    always_comb
    begin
        priority if (date.month >= nstld_pkg::MONTH_APR && date.month <= nstld_pkg::MONTH_SEP)
            summer = 1'b1;
        else if (date.month == nstld_pkg::MONTH_MAR)
            summer = past_last_sunday && (not_sunday || tod.hour >= nstld_pkg::DST_START_HOUR);
        else if (date.month == nstld_pkg::MONTH_OCT)
            summer = !(past_last_sunday && (not_sunday || tod.hour >= nstld_pkg::DST_END_HOUR));
        else
            summer = 1'b0;
    end

    // The summer hour rolls into the next day only from 23:00
    assign day_roll = summer && (tod.hour == nstld_pkg::LAST_HOUR);

    always_comb
    begin
        result_next.year   = date.year;
        result_next.month  = date.month;
        result_next.mday   = date.mday;
        result_next.hour   = tod.hour;
        result_next.minute = tod.minute;
        result_next.second = tod.second;
        result_next.summer = summer;
        if (summer)
        begin
            result_next.hour = day_roll ? 5'd0 : tod.hour + 5'd1;
        end
        if (day_roll)
        begin
            if (date.mday == nstld_pkg::month_length(date.month))
            begin
                result_next.mday = 5'd1;
                if (date.month == nstld_pkg::MONTH_DEC)
                begin
                    result_next.month = nstld_pkg::MONTH_JAN;
                    result_next.year  = date.year + 8'd1;
                end
                else
                begin
                    result_next.month = date.month + 4'd1;
                end
            end
            else
            begin
                result_next.mday = date.mday + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[nstld_pkg::ST_OUT])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* design/network_seconds_to_local_date.sv */
// ----------------------------------------------------------------------------
// network_seconds_to_local_date
// Time-server second count to local calendar date with European summer time.
// ----------------------------------------------------------------------------
// Usage:
//   seconds    - request channel; each request carries a 32-bit count of
//                seconds since 1900-01-01 00:00 UTC.
//   local_date - result channel; one result per request, in request order:
//                year since 1900, month (0 is January), day, hour, minute,
//                second and a flag for the added summer hour.
//   cfg_write_en / cfg_write_data - write the signed whole-hour zone offset;
//                write only while no request is in flight.
// Throughput is one request per cycle while the receiver takes results: ten
// register stages run with their own valid bits.
// Reset clears all stage valid bits and sets the zone offset to +1 hour.
// When the receiver stalls, the output stage holds its result; stages behind
// it keep filling empty slots, so seconds.ready falls only when every stage
// holds a request.
// ----------------------------------------------------------------------------
module network_seconds_to_local_date (
    input  logic                  clk,
    input  logic                  rst_n,
    nstld_seconds_if.sink         seconds,
    nstld_date_if.source          local_date,
    input  logic                  cfg_write_en,
    input  logic signed [4:0]     cfg_write_data
);

    logic signed [4:0]     zone_offset_reg;
    nstld_pkg::pipe_ctrl_t ctrl;
    logic [16:0]           dayno;
    nstld_pkg::tod_t       tod;
    nstld_pkg::date_t      date;
    nstld_pkg::result_t    result;

    // Zone offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_offset_reg <= nstld_pkg::ZONE_OFFSET_RESET;
        end
        else if (cfg_write_en)
        begin
            zone_offset_reg <= cfg_write_data;
        end
    end

    // Stage valid bits and load enables
    nstld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seconds.valid),
        .in_ready  (seconds.ready),
        .out_valid (local_date.valid),
        .out_ready (local_date.ready),
        .ctrl      (ctrl)
    );

    // Day number and standard-time time of day
    nstld_split u_split (
        .clk         (clk),
        .ctrl        (ctrl),
        .zone_offset (zone_offset_reg),
        .seconds     (seconds.seconds_since_1900),
        .dayno       (dayno),
        .tod         (tod)
    );

    // Calendar date of the standard-time day, in step with the time of day
    nstld_civil u_civil (
        .clk   (clk),
        .ctrl  (ctrl),
        .dayno (dayno),
        .date  (date)
    );

    // Summer rule, advance hour and date, and hold the result
    nstld_dst u_dst (
        .clk    (clk),
        .ctrl   (ctrl),
        .date   (date),
        .tod    (tod),
        .result (result)
    );

    assign local_date.years_since_1900 = result.year;
    assign local_date.month_index      = result.month;
    assign local_date.day_of_month     = result.mday;
    assign local_date.hour_of_day      = result.hour;
    assign local_date.minute_of_hour   = result.minute;
    assign local_date.second_of_minute = result.second;
    assign local_date.summer_time      = result.summer;

endmodule

/* design/nstld_checker.sv */
// ----------------------------------------------------------------------------
// nstld_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module nstld_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] year,
    input  logic [3:0] month,
    input  logic [4:0] mday,
    input  logic [4:0] hour,
    input  logic [5:0] minute,
    input  logic [5:0] second,
    input  logic       summer
);

    // No result shows while reset is applied
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({year, month, mday, hour, minute, second, summer}))
        else $error("stalled result changed");

    // Every field of a result is a real calendar value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> month <= 4'd11 && mday >= 5'd1 && mday <= 5'd31
            && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
        else $error("result field out of range");

    // The summer hour only lands in March through October
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && summer |-> month >= nstld_pkg::MONTH_MAR && month <= nstld_pkg::MONTH_OCT)
        else $error("summer hour outside summer months");

endmodule

bind network_seconds_to_local_date nstld_checker u_nstld_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (local_date.valid),
    .out_ready (local_date.ready),
    .year      (local_date.years_since_1900),
    .month     (local_date.month_index),
    .mday      (local_date.day_of_month),
    .hour      (local_date.hour_of_day),
    .minute    (local_date.minute_of_hour),
    .second    (local_date.second_of_minute),
    .summer    (local_date.summer_time)
);

/* bench/nstld_date_checker.sv */
// ----------------------------------------------------------------------------
// nstld_date_checker
// Watches both channels of the seconds-to-local-date block, predicts the
// local date of every accepted request and compares each result with it.
// ----------------------------------------------------------------------------
module nstld_date_checker (
    input  logic              clk,
    input  logic              rst_n,
    nstld_seconds_if          seconds,
    nstld_date_if             local_date,
    input  logic              cfg_write_en,
    input  logic signed [4:0] cfg_write_data,
    output int                mismatches,
    output int                pending
);

    // Days from 0000-03-01 to 1900-01-01, less one for the extra day added
    localparam longint unsigned DAYS_TO_EPOCH = 693900;
    localparam longint unsigned DAYS_PER_ERA  = 146097;

    logic signed [4:0]    zone_hours;
    nstld_pkg::result_t   expected_dates [$];

    initial mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Standard-time calendar split of a count that already holds one extra day
    function automatic nstld_pkg::result_t split_calendar(input longint unsigned t,
                                                          output logic [2:0] wday);
        nstld_pkg::result_t c;
        longint unsigned    dayno, sod, z, era, doe, yoe, yr, doy, mp, d, m;
        dayno = t / nstld_pkg::SECS_PER_DAY;
        sod   = t % nstld_pkg::SECS_PER_DAY;
        z     = dayno + DAYS_TO_EPOCH;
        era   = z / DAYS_PER_ERA;
        doe   = z - era * DAYS_PER_ERA;
        yoe   = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        yr    = yoe + era * 400;
        doy   = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp    = (5 * doy + 2) / 153;
        d     = doy - (153 * mp + 2) / 5 + 1;
        m     = (mp < 10) ? mp + 3 : mp - 9;
        if (m <= 2)
            yr++;
        c.year   = 8'(yr + 256 - 1900);
        c.month  = 4'(m - 1);
        c.mday   = 5'(d);
        c.hour   = 5'(sod / nstld_pkg::SECS_PER_HOUR);
        c.minute = 6'((sod / nstld_pkg::SECS_PER_MIN) % nstld_pkg::SECS_PER_MIN);
        c.second = 6'(sod % nstld_pkg::SECS_PER_MIN);
        c.summer = 1'b0;
        // 1900-01-01 was a Monday and dayno runs one day ahead
        wday     = 3'(dayno % nstld_pkg::DAYS_PER_WEEK);
        return c;
    endfunction

    function automatic logic in_summer_time(input nstld_pkg::result_t c,
                                            input logic [2:0] wday);
        logic past_last_sunday;
        past_last_sunday = (c.mday >= wday + nstld_pkg::LAST_SUNDAY_MIN_DAY);
        if (c.month >= nstld_pkg::MONTH_APR && c.month <= nstld_pkg::MONTH_SEP)
            return 1'b1;
        if (c.month == nstld_pkg::MONTH_MAR)
            return past_last_sunday && (wday != nstld_pkg::WDAY_SUNDAY
                                        || c.hour >= nstld_pkg::DST_START_HOUR);
        if (c.month == nstld_pkg::MONTH_OCT)
            return !(past_last_sunday && (wday != nstld_pkg::WDAY_SUNDAY
                                          || c.hour >= nstld_pkg::DST_END_HOUR));
        return 1'b0;
    endfunction

    function automatic nstld_pkg::result_t predict_local_date(input logic [31:0] secs,
                                                              input logic signed [4:0] zone);
        longint             t;
        nstld_pkg::result_t r;
        logic [2:0]         wd;
        t = longint'(secs) + longint'(zone) * longint'(nstld_pkg::SECS_PER_HOUR)
            + longint'(nstld_pkg::SECS_PER_DAY);
        r = split_calendar(t, wd);
        if (in_summer_time(r, wd))
        begin
            r = split_calendar(t + longint'(nstld_pkg::SECS_PER_HOUR), wd);
            r.summer = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        nstld_pkg::result_t want;
        if (!rst_n)
        begin
            zone_hours = nstld_pkg::ZONE_OFFSET_RESET;
            expected_dates.delete();
            pending <= 0;
        end
        else
        begin
            // A request taken at the write edge still sees the old offset
            if (seconds.valid && seconds.ready)
                expected_dates.push_back(
                    predict_local_date(seconds.seconds_since_1900, zone_hours));
            if (cfg_write_en)
                zone_hours = cfg_write_data;
            if (local_date.valid && local_date.ready)
            begin
                if (expected_dates.size() == 0)
                    report_mismatch("result with no request waiting");
                else
                begin
                    want = expected_dates.pop_front();
                    check_field("year", local_date.years_since_1900, want.year);
                    check_field("month", local_date.month_index, want.month);
                    check_field("day", local_date.day_of_month, want.mday);
                    check_field("hour", local_date.hour_of_day, want.hour);
                    check_field("minute", local_date.minute_of_hour, want.minute);
                    check_field("second", local_date.second_of_minute, want.second);
                    check_field("summer", local_date.summer_time, want.summer);
                end
            end
            pending <= expected_dates.size();
        end
    end

endmodule

/* bench/tb_network_seconds_to_local_date.sv */
// ----------------------------------------------------------------------------
// tb_network_seconds_to_local_date
// Drives second counts into the block under several zone offsets, with random
// gaps and stalls on both channels; a checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module tb_network_seconds_to_local_date;

    localparam int CYCLE_LIMIT    = 200000;  // far above the slowest legal run
    localparam int RANDOM_PER_SET = 125;     // random requests per zone setting
    localparam int NUM_SETTINGS   = 8;
    localparam int HOLD_CYCLES    = 60;      // long receiver hold-off
    localparam int IDLE_PERCENT   = 8;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write_en;
    logic signed [4:0] cfg_write_data;
    int                mismatches;
    int                pending;
    int                cycle_count = 0;

    // Pacing controls: no_gaps for the sender and the receiver, hold_output for the receiver
    logic no_gaps     = 1'b0;
    logic hold_output = 1'b0;

    logic signed [4:0] zone_now;

    nstld_seconds_if seconds_ch ();
    nstld_date_if    date_ch ();

    network_seconds_to_local_date i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .seconds        (seconds_ch),
        .local_date     (date_ch),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    nstld_date_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .seconds        (seconds_ch),
        .local_date     (date_ch),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    always #6 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[network_seconds_to_local_date] ERROR");
            $finish;
        end
    end

    // UTC second count of a standard-time local date at the given zone.
    // month runs 1..12 here; the count wraps at 32 bits like the wire does.
    function automatic logic [31:0] seconds_at(input int year, input int month,
                                               input int day, input int hour,
                                               input int minute, input int sec,
                                               input logic signed [4:0] zone);
        int     y, era, yoe, mp, doy, doe;
        longint days, s;
        y    = (month <= 2) ? year - 1 : year;
        era  = y / 400;
        yoe  = y - era * 400;
        mp   = (month > 2) ? month - 3 : month + 9;
        doy  = (153 * mp + 2) / 5 + day - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = longint'(era) * 146097 + doe - 693901;
        s    = days * 86400 + hour * 3600 + minute * 60 + sec - longint'(zone) * 3600;
        return 32'(s);
    endfunction

    // Mostly land around the summer-time switches; the rest hits month and
    // year edges, the ends of the input range, and plain random counts.
    function automatic logic [31:0] random_seconds(input logic signed [4:0] zone);
        int year, minute, sec;
        year   = 1900 + $urandom_range(135);
        minute = $urandom_range(1) ? 59 : $urandom_range(59);
        sec    = $urandom_range(1) ? 59 : $urandom_range(59);
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5:
                return seconds_at(year, $urandom_range(1) ? 3 : 10, $urandom_range(31, 22),
                                  $urandom_range(4), minute, sec, zone);
            6:
                return seconds_at(year, $urandom_range(12, 1), 1, 0, 0, 0, zone)
                       + $urandom_range(4) - 2;
            7:
                return $urandom_range(1) ? 32'($urandom_range(200000))
                                         : 32'hFFFF_FFFF - $urandom_range(200000);
            default:
                return $urandom;
        endcase
    endfunction

    // Offer one request, idling at random first, and hold it until accepted.
    // Leave valid high on return so back-to-back requests need no bubble.
    task automatic send_request(input logic [31:0] secs);
        while (!no_gaps && $urandom_range(99) < IDLE_PERCENT)
        begin
            seconds_ch.valid <= 1'b0;
            @(posedge clk);
        end
        seconds_ch.valid              <= 1'b1;
        seconds_ch.seconds_since_1900 <= secs;
        do
            @(posedge clk);
        while (!seconds_ch.ready);
    endtask

    // Drop valid, wait until every result is back, then idle on before returning.
    // The first edge lets the checker count the last accepted request.
    task automatic drain_results();
        seconds_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (nstld_pkg::NUM_STAGES + 2) @(posedge clk);
    endtask

    task automatic write_zone(input logic signed [4:0] zone);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= zone;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // Receiver: random stalls, a no-stall stretch, and one long hold-off that
    // fills the pipeline and pushes back on the sender
    initial
    begin
        date_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                date_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            date_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin
        logic signed [4:0] zone_plan [NUM_SETTINGS];
        logic signed [4:0] z;

        // Setting 0 runs at the reset offset; the rest hit both ends of the
        // meant range, zero, both ends of the register, and two random zones
        zone_plan[0] = nstld_pkg::ZONE_OFFSET_RESET;
        zone_plan[1] = -5'sd12;
        zone_plan[2] = 5'sd12;
        zone_plan[3] = 5'sd0;
        zone_plan[4] = -5'sd16;
        zone_plan[5] = 5'sd15;
        zone_plan[6] = 5'($urandom_range(24)) - 5'sd12;
        zone_plan[7] = 5'($urandom_range(24)) - 5'sd12;

        rst_n                         <= 1'b0;
        cfg_write_en                  <= 1'b0;
        cfg_write_data                <= nstld_pkg::ZONE_OFFSET_RESET;
        seconds_ch.valid              <= 1'b0;
        seconds_ch.seconds_since_1900 <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset offset
        z = nstld_pkg::ZONE_OFFSET_RESET;
        send_request(32'd0);
        send_request(32'd1);
        send_request(32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF - 32'd3600);
        send_request(32'd2208988800);                   // start of 1970
        send_request(32'd86399);
        // Summer begins on the last Sunday of March at 02:00 standard time
        send_request(seconds_at(2021, 3, 28, 1, 59, 59, z));
        send_request(seconds_at(2021, 3, 28, 2, 0, 0, z));
        // Summer ends on the last Sunday of October at 03:00 standard time
        send_request(seconds_at(2021, 10, 31, 2, 59, 59, z));
        send_request(seconds_at(2021, 10, 31, 3, 0, 0, z));
        // March before its last Sunday stays winter, earlier Sundays too
        send_request(seconds_at(2021, 3, 27, 23, 59, 59, z));
        send_request(seconds_at(2021, 3, 21, 12, 0, 0, z));
        // Last Sunday on the 31st and on the 25th
        send_request(seconds_at(2024, 3, 31, 2, 0, 0, z));
        send_request(seconds_at(2026, 10, 25, 3, 0, 0, z));
        send_request(seconds_at(2026, 10, 25, 2, 0, 0, z));
        send_request(seconds_at(2026, 10, 24, 12, 0, 0, z));
        // Leap day, the non-leap 1900, year end
        send_request(seconds_at(2000, 2, 29, 12, 0, 0, z));
        send_request(seconds_at(1900, 2, 28, 23, 0, 0, z));
        send_request(seconds_at(2000, 12, 31, 23, 59, 59, z));
        // Summer hour carries the date into the next month; two winter dates follow
        send_request(seconds_at(2021, 6, 30, 23, 30, 0, z));
        send_request(seconds_at(2021, 9, 30, 23, 30, 0, z));
        send_request(seconds_at(2021, 1, 15, 12, 0, 0, z));
        send_request(seconds_at(2035, 12, 31, 23, 59, 59, z));

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            // Change the zone only with the pipeline empty
            if (p > 0)
            begin
                drain_results();
                write_zone(zone_plan[p]);
            end
            zone_now = zone_plan[p];
            no_gaps  = (p == 2);
            if (p == 4)
                hold_output = 1'b1;
            // Range ends; at negative zones the count 0 lands in 1899
            send_request(32'd0);
            send_request(32'hFFFF_FFFF);
            for (int i = 0; i < RANDOM_PER_SET; i++)
                send_request(random_seconds(zone_now));
        end

        drain_results();
        if (mismatches == 0)
            $display("[network_seconds_to_local_date] OK");
        else
            $display("[network_seconds_to_local_date] ERROR");
        $finish;
    end

endmodule

/* sim.f */
design/nstld_pkg.sv
design/nstld_stream_if.sv
design/nstld_ctrl.sv
design/nstld_split.sv
design/nstld_civil.sv
design/nstld_dst.sv
design/network_seconds_to_local_date.sv
design/nstld_checker.sv
bench/nstld_date_checker.sv
bench/tb_network_seconds_to_local_date.sv
